@@ src/em2cd_pkg.sv @@
// constants and reciprocal factors for the epoch minutes to calendar date converter
`default_nettype none

package em2cd_pkg;

  // field widths
  localparam int unsigned MinutesW = 32;
  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 40;

  // pipeline depth
  localparam int unsigned NumStages = 10;

  // julian day of the epoch plus the algorithm's 32044 offset
  localparam logic [22:0] EpochAOffset = 23'(2440588 + 32044);
  localparam logic [13:0] YearBias     = 14'(4800);

  // exact reciprocals: q = (n * ceil(2^s / d)) >> s for n below 2^(s - ceil(log2 d))
  localparam int unsigned R45Shift = 33;
  localparam logic [27:0] Recip45  = 28'(((64'd1 << R45Shift) + 64'd44) / 64'd45);

  localparam int unsigned R60Shift = 17;
  localparam logic [11:0] Recip60  = 12'(((64'd1 << R60Shift) + 64'd59) / 64'd60);

  localparam int unsigned RCentShift = 43;
  localparam logic [25:0] RecipCent  =
      26'(((64'd1 << RCentShift) + 64'd146096) / 64'd146097);

  localparam int unsigned RQuadShift = 29;
  localparam logic [18:0] RecipQuad  = 19'(((64'd1 << RQuadShift) + 64'd1460) / 64'd1461);

  localparam int unsigned RMonShift = 19;
  localparam logic [11:0] RecipMon  = 12'(((64'd1 << RMonShift) + 64'd152) / 64'd153);

  localparam int unsigned R5Shift = 11;
  localparam logic [8:0]  Recip5  = 9'(((64'd1 << R5Shift) + 64'd4) / 64'd5);

endpackage

`default_nettype wire

@@ src/epoch_minutes_to_calendar_date_top.sv @@
// epoch minutes to gregorian date and time of day, ten-stage pipeline
`default_nettype none

// Converts an unsigned 32-bit count of minutes since 1970-01-01 00:00 into a
// Gregorian year, month, day, hour and minute, one result beat for every input
// beat. The block is a ten-stage pipeline with a valid bit per stage: it takes
// one beat per clock cycle while its input is ready. Every constant division
// is an exact multiply by a reciprocal, the quotient taken in the next stage,
// so the stage depth is set by the widest product (27 x 28 bits for the split
// into days). A stall on the output only holds the stages that are full;
// empty stages keep filling, so the input stays ready until the whole pipe is
// occupied. There is no state besides the pipeline and no setup.
module epoch_minutes_to_calendar_date_top
  import em2cd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input beat
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,   // [31:0] minutes_since_epoch
  // result beat
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute, rest zero
  output logic [OutTdataW-1:0]      m_axis_tdata_o
);

  // ---------------------------------------------------------------------------
  // flow control: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] in_vld;
  logic [NumStages-1:0] ld;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    in_vld = {vld_q[NumStages-2:0], s_axis_tvalid_i};
    ld     = rdy & in_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NumStages; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= in_vld[i];
        end
      end
    end
  end

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = vld_q[NumStages-1];

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  // stage 1: minutes / 32, then times reciprocal of 45
  logic [26:0] s1_q1_q;
  logic [4:0]  s1_r1_q;
  logic [54:0] s1_p_q;
  // stage 2: whole days and minute of day
  logic [21:0] s2_days_q;
  logic [10:0] s2_mod_q;
  // stage 3: 4a+3 times reciprocal of 146097, minute of day times 1/60
  logic [24:0] s3_n_q;
  logic [50:0] s3_p_q;
  logic [10:0] s3_mod_q;
  logic [22:0] s3_ph_q;
  // stage 4: centuries b and remainder, hour and minute
  logic [17:0] s4_r_q;
  logic [7:0]  s4_b_q;
  logic [HourW-1:0]   s4_hour_q;
  logic [MinuteW-1:0] s4_min_q;
  // stage 5: 4c+3 times reciprocal of 1461
  logic [17:0] s5_n_q;
  logic [36:0] s5_p_q;
  logic [7:0]  s5_b_q;
  logic [HourW-1:0]   s5_hour_q;
  logic [MinuteW-1:0] s5_min_q;
  // stage 6: years d within century and remainder
  logic [10:0] s6_r_q;
  logic [6:0]  s6_d_q;
  logic [7:0]  s6_b_q;
  logic [HourW-1:0]   s6_hour_q;
  logic [MinuteW-1:0] s6_min_q;
  // stage 7: 5e+2 times reciprocal of 153
  logic [10:0] s7_n_q;
  logic [22:0] s7_p_q;
  logic [6:0]  s7_d_q;
  logic [7:0]  s7_b_q;
  logic [HourW-1:0]   s7_hour_q;
  logic [MinuteW-1:0] s7_min_q;
  // stage 8: shifted month m and remainder
  logic [7:0]  s8_r_q;
  logic [3:0]  s8_m_q;
  logic [6:0]  s8_d_q;
  logic [7:0]  s8_b_q;
  logic [HourW-1:0]   s8_hour_q;
  logic [MinuteW-1:0] s8_min_q;
  // stage 9: remainder times 1/5, year before month wrap
  logic [16:0] s9_p_q;
  logic [3:0]  s9_m_q;
  logic [YearW-1:0]   s9_yp_q;
  logic [HourW-1:0]   s9_hour_q;
  logic [MinuteW-1:0] s9_min_q;
  // stage 10: output register
  logic [YearW-1:0]   s10_year_q;
  logic [MonthW-1:0]  s10_month_q;
  logic [DayW-1:0]    s10_day_q;
  logic [HourW-1:0]   s10_hour_q;
  logic [MinuteW-1:0] s10_min_q;

  // ---------------------------------------------------------------------------
  // combinational next values
  // ---------------------------------------------------------------------------
  logic [26:0] s1_q1_d;
  logic [54:0] s1_p_d;
  logic [21:0] s2_days_d;
  logic [26:0] s2_rem_full;
  logic [10:0] s2_mod_d;
  logic [24:0] s3_n_d;
  logic [50:0] s3_p_d;
  logic [22:0] s3_ph_d;
  logic [7:0]  s4_b_d;
  logic [24:0] s4_rem_full;
  logic [HourW-1:0] s4_hour_d;
  logic [10:0] s4_min_full;
  logic [17:0] s5_n_d;
  logic [36:0] s5_p_d;
  logic [6:0]  s6_d_d;
  logic [17:0] s6_rem_full;
  logic [8:0]  s7_e;
  logic [10:0] s7_n_d;
  logic [22:0] s7_p_d;
  logic [3:0]  s8_m_d;
  logic [10:0] s8_rem_full;
  logic [16:0] s9_p_d;
  logic [YearW-1:0] s9_yp_d;
  logic             s10_wrap;
  logic [DayW-1:0]  s10_day_d;
  logic [MonthW-1:0] s10_month_d;
  logic [YearW-1:0] s10_year_d;

  always_comb begin
    // minutes per day is 32 * 45: shift off the 32, multiply for the 45
    s1_q1_d = s_axis_tdata_i[31:5];
    s1_p_d  = {28'b0, s1_q1_d} * {27'b0, Recip45};

    s2_days_d   = 22'(s1_p_q >> R45Shift);
    s2_rem_full = s1_q1_q - 27'(45) * {5'b0, s2_days_d};
    s2_mod_d    = {s2_rem_full[5:0], s1_r1_q};

    // a = jdn + 32044, then 4a+3 into the century division
    s3_n_d  = {23'({1'b0, s2_days_q} + EpochAOffset), 2'b11};
    s3_p_d  = {26'b0, s3_n_d} * {25'b0, RecipCent};
    s3_ph_d = {12'b0, s2_mod_q} * {11'b0, Recip60};

    s4_b_d      = 8'(s3_p_q >> RCentShift);
    s4_rem_full = s3_n_q - 25'(146097) * {17'b0, s4_b_d};
    s4_hour_d   = HourW'(s3_ph_q >> R60Shift);
    s4_min_full = s3_mod_q - 11'(60) * {6'b0, s4_hour_d};

    // c is the remainder over four, so 4c+3 keeps its upper bits
    s5_n_d = {s4_r_q[17:2], 2'b11};
    s5_p_d = {19'b0, s5_n_d} * {18'b0, RecipQuad};

    s6_d_d      = 7'(s5_p_q >> RQuadShift);
    s6_rem_full = s5_n_q - 18'(1461) * {11'b0, s6_d_d};

    // e is the remainder over four, then 5e+2 into the month division
    s7_e   = s6_r_q[10:2];
    s7_n_d = {s7_e, 2'b00} + {2'b0, s7_e} + 11'd2;
    s7_p_d = {12'b0, s7_n_d} * {11'b0, RecipMon};

    s8_m_d      = 4'(s7_p_q >> RMonShift);
    s8_rem_full = s7_n_q - 11'(153) * {7'b0, s8_m_d};

    // day of month is the month remainder over five, plus one
    s9_p_d  = {9'b0, s8_r_q} * {8'b0, Recip5};
    s9_yp_d = 14'(100) * {6'b0, s8_b_q} + {7'b0, s8_d_q};

    // march-based month wraps to january and february of the next year
    s10_wrap    = (s9_m_q >= 4'd10);
    s10_day_d   = DayW'(s9_p_q >> R5Shift) + DayW'(1);
    s10_month_d = s10_wrap ? (s9_m_q - 4'd9) : (s9_m_q + 4'd3);
    s10_year_d  = s9_yp_q + {13'b0, s10_wrap} - YearBias;
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s1_q1_q <= s1_q1_d;
      s1_r1_q <= s_axis_tdata_i[4:0];
      s1_p_q  <= s1_p_d;
    end
    if (ld[1]) begin
      s2_days_q <= s2_days_d;
      s2_mod_q  <= s2_mod_d;
    end
    if (ld[2]) begin
      s3_n_q   <= s3_n_d;
      s3_p_q   <= s3_p_d;
      s3_mod_q <= s2_mod_q;
      s3_ph_q  <= s3_ph_d;
    end
    if (ld[3]) begin
      s4_r_q    <= s4_rem_full[17:0];
      s4_b_q    <= s4_b_d;
      s4_hour_q <= s4_hour_d;
      s4_min_q  <= s4_min_full[5:0];
    end
    if (ld[4]) begin
      s5_n_q    <= s5_n_d;
      s5_p_q    <= s5_p_d;
      s5_b_q    <= s4_b_q;
      s5_hour_q <= s4_hour_q;
      s5_min_q  <= s4_min_q;
    end
    if (ld[5]) begin
      s6_r_q    <= s6_rem_full[10:0];
      s6_d_q    <= s6_d_d;
      s6_b_q    <= s5_b_q;
      s6_hour_q <= s5_hour_q;
      s6_min_q  <= s5_min_q;
    end
    if (ld[6]) begin
      s7_n_q    <= s7_n_d;
      s7_p_q    <= s7_p_d;
      s7_d_q    <= s6_d_q;
      s7_b_q    <= s6_b_q;
      s7_hour_q <= s6_hour_q;
      s7_min_q  <= s6_min_q;
    end
    if (ld[7]) begin
      s8_r_q    <= s8_rem_full[7:0];
      s8_m_q    <= s8_m_d;
      s8_d_q    <= s7_d_q;
      s8_b_q    <= s7_b_q;
      s8_hour_q <= s7_hour_q;
      s8_min_q  <= s7_min_q;
    end
    if (ld[8]) begin
      s9_p_q    <= s9_p_d;
      s9_m_q    <= s8_m_q;
      s9_yp_q   <= s9_yp_d;
      s9_hour_q <= s8_hour_q;
      s9_min_q  <= s8_min_q;
    end
    if (ld[9]) begin
      s10_year_q  <= s10_year_d;
      s10_month_q <= s10_month_d;
      s10_day_q   <= s10_day_d;
      s10_hour_q  <= s9_hour_q;
      s10_min_q   <= s9_min_q;
    end
  end

  assign m_axis_tdata_o = {6'b0, s10_min_q, s10_hour_q, s10_day_q, s10_month_q, s10_year_q};

endmodule

`default_nettype wire

@@ sim/epoch_minutes_to_calendar_date_top_test.sv @@
// self-checking testbench for the epoch minutes to calendar date converter
`default_nettype none

module epoch_minutes_to_calendar_date_top_test;
  import em2cd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // julian day number of 1970-01-01
  localparam longint unsigned EpochJdn    = 64'd2440588;
  localparam longint unsigned MinPerDay   = 64'd1440;
  localparam longint unsigned MaxMinutes  = 64'hFFFF_FFFF;
  // last day whose every minute still fits in 32 bits
  localparam int unsigned     LastFullDay = 2982615;
  // receiver hold-off, long enough to back the pipe up to the input
  localparam int unsigned     HoldCycles  = 300;
  localparam int unsigned     PhaseBeats  = 470;

  // one expected result, year in the low bits as on the bus
  typedef struct packed {
    logic [MinuteW-1:0] minute;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
  } cal_stamp_t;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;   // [31:0] minutes_since_epoch
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute, rest zero
  logic [OutTdataW-1:0] m_axis_tdata_o;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct  = 0;
  logic        rx_hold       = 1'b0;
  logic        hold_go       = 1'b0;
  int unsigned err_count     = 0;

  logic [31:0] minutes_pending[$];
  cal_stamp_t  expected_dates[$];

  epoch_minutes_to_calendar_date_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // whole days plus julian day of the epoch, then the integer julian-day to
  // gregorian conversion; minute of day splits into hour and minute
  function automatic cal_stamp_t civil_from_minutes(input logic [31:0] stamp);
    longint unsigned count, days, tod, jday_off, cent, rem_c, quad, rem_q, mshift, wrap;
    cal_stamp_t r;
    count    = 64'(stamp);
    days     = count / MinPerDay;
    tod      = count % MinPerDay;
    jday_off = EpochJdn + days + 64'd32044;
    cent     = (64'd4 * jday_off + 64'd3) / 64'd146097;
    rem_c    = jday_off - (64'd146097 * cent) / 64'd4;
    quad     = (64'd4 * rem_c + 64'd3) / 64'd1461;
    rem_q    = rem_c - (64'd1461 * quad) / 64'd4;
    mshift   = (64'd5 * rem_q + 64'd2) / 64'd153;
    wrap     = mshift / 64'd10;
    r.day    = DayW'(rem_q - (64'd153 * mshift + 64'd2) / 64'd5 + 64'd1);
    r.month  = MonthW'(mshift + 64'd3 - 64'd12 * wrap);
    r.year   = YearW'(64'd100 * cent + quad + wrap - 64'd4800);
    r.hour   = HourW'(tod / 64'd60);
    r.minute = MinuteW'(tod % 64'd60);
    return r;
  endfunction

  // minutes since the epoch for a calendar date and time, may exceed 32 bits
  function automatic longint unsigned minutes_at(input int yr, input int mo, input int dy,
                                                 input int hr, input int mi);
    longint a, y2, m2, jday;
    a    = (14 - mo) / 12;
    y2   = yr + 4800 - a;
    m2   = mo + 12 * a - 3;
    jday = dy + (153 * m2 + 2) / 5 + 365 * y2 + y2 / 4 - y2 / 100 + y2 / 400 - 32045;
    return (jday - longint'(EpochJdn)) * 1440 + hr * 60 + mi;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      err_count++;
    end
  endtask

  // block the caller until nothing is queued, in flight or owed
  task automatic wait_drained();
    while (minutes_pending.size() != 0 || s_axis_tvalid_i || expected_dates.size() != 0)
      @(negedge clk_i);
  endtask

  // random beats with a bias toward day, month, leap and range boundaries
  task automatic run_phase(input int unsigned beats, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    longint unsigned stamp;
    int unsigned kind, yr;
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    for (int unsigned i = 0; i < beats; i++) begin
      kind = $urandom_range(5);
      case (kind)
        0, 1: begin
          stamp = 64'($urandom);
        end
        2: begin
          // edges of a day: midnight, hour turns, last minutes
          stamp = 64'($urandom_range(LastFullDay)) * MinPerDay;
          case ($urandom_range(4))
            0: stamp += 0;
            1: stamp += 1;
            2: stamp += 59 + $urandom_range(1);
            3: stamp += 1380 + $urandom_range(58);
            default: stamp += 1439;
          endcase
        end
        3: begin
          // month ends, leap days, new year and other dates of a random year
          yr = $urandom_range(1970, 10135);
          case ($urandom_range(4))
            0: stamp = minutes_at(yr, 2, 28, $urandom_range(23), $urandom_range(59));
            1: stamp = minutes_at(yr, 2, 29, $urandom_range(23), $urandom_range(59));
            2: stamp = minutes_at(yr, 3, 1, 0, $urandom_range(59));
            3: stamp = minutes_at(yr, 12, 31, 23, 59);
            default: stamp = minutes_at(yr, $urandom_range(1, 12), $urandom_range(1, 28),
                                        $urandom_range(23), $urandom_range(59));
          endcase
          if (stamp > MaxMinutes) stamp = 64'($urandom);
        end
        4: begin
          stamp = 64'($urandom_range(3 * 1440 * 366));
        end
        default: begin
          stamp = MaxMinutes - 64'($urandom_range(1_000_000));
        end
      endcase
      minutes_pending.push_back(stamp[31:0]);
    end
    wait_drained();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // sender: offers the next queued value once the current beat is taken, unless it idles;
  // each accepted beat lines up its expected date
  always @(posedge clk_i or negedge rst_ni) begin
    logic        nxt_valid;
    logic [31:0] nxt_data;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      nxt_valid = s_axis_tvalid_i;
      nxt_data  = s_axis_tdata_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_dates.push_back(civil_from_minutes(s_axis_tdata_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && minutes_pending.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt_data  = minutes_pending.pop_front();
        nxt_valid = 1'b1;
      end
      s_axis_tvalid_i <= nxt_valid;
      s_axis_tdata_i  <= nxt_data;
    end
  end

  // receiver: random stalls, forced low during the hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // checker: every result beat against the oldest expected date
  always @(posedge clk_i) begin
    cal_stamp_t want;
    cal_stamp_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[$bits(cal_stamp_t)-1:0];
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time,
                 m_axis_tdata_o);
        err_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("year",   32'(want.year),   32'(got.year));
        check_field("month",  32'(want.month),  32'(got.month));
        check_field("day",    32'(want.day),    32'(got.day));
        check_field("hour",   32'(want.hour),   32'(got.hour));
        check_field("minute", 32'(want.minute), 32'(got.minute));
        check_field("padding", 32'd0, 32'(m_axis_tdata_o[OutTdataW-1:$bits(cal_stamp_t)]));
      end
    end
  end

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, day and hour turns, leap and century rules
    minutes_pending.push_back(32'd0);
    minutes_pending.push_back(32'd1);
    minutes_pending.push_back(32'd59);
    minutes_pending.push_back(32'd60);
    minutes_pending.push_back(32'd1439);
    minutes_pending.push_back(32'd1440);
    minutes_pending.push_back(32'hFFFF_FFFF);
    minutes_pending.push_back(32'hFFFF_FFFE);
    minutes_pending.push_back(32'h8000_0000);
    minutes_pending.push_back(32'h7FFF_FFFF);
    minutes_pending.push_back(32'h5555_5555);
    minutes_pending.push_back(32'hAAAA_AAAA);
    minutes_pending.push_back(32'(64'(LastFullDay + 1) * MinPerDay));
    minutes_pending.push_back(32'(minutes_at(1970, 12, 31, 23, 59)));
    minutes_pending.push_back(32'(minutes_at(1971, 1, 1, 0, 0)));
    minutes_pending.push_back(32'(minutes_at(1972, 2, 29, 23, 59)));
    minutes_pending.push_back(32'(minutes_at(1972, 3, 1, 0, 0)));
    minutes_pending.push_back(32'(minutes_at(1999, 12, 31, 23, 59)));
    minutes_pending.push_back(32'(minutes_at(2000, 2, 29, 12, 34)));
    minutes_pending.push_back(32'(minutes_at(2000, 3, 1, 0, 0)));
    minutes_pending.push_back(32'(minutes_at(2100, 2, 28, 23, 59)));
    minutes_pending.push_back(32'(minutes_at(2100, 3, 1, 0, 0)));
    minutes_pending.push_back(32'(minutes_at(2400, 2, 29, 6, 30)));
    minutes_pending.push_back(32'(minutes_at(9999, 12, 31, 23, 59)));
    wait_drained();

    // random traffic, back-to-back and with sender idling and receiver stalls, receiver held off for a while
    hold_go = 1'b1;
    run_phase(PhaseBeats, 0, 0);
    run_phase(PhaseBeats, 55, 0);
    run_phase(PhaseBeats, 0, 55);
    run_phase(PhaseBeats, 13, 13);

    // catch stray beats past the pipeline depth
    repeat (NumStages + 8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("epoch_minutes_to_calendar_date_top_test: done, clean");
    end else begin
      $display("epoch_minutes_to_calendar_date_top_test: done, errors");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #200_000;
    $display("%0t: timeout", $time);
    $display("epoch_minutes_to_calendar_date_top_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/em2cd_pkg.sv
src/epoch_minutes_to_calendar_date_top.sv
sim/epoch_minutes_to_calendar_date_top_test.sv
